// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the square duty wave generator.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/sdwg_pkg.sv -----
// Shared types, constants and the duty pattern lookup for the square duty wave generator.
// No dependencies; imported by square_duty_wave_generator and the testbench.
package sdwg_pkg;

   // Field widths.
   localparam int FREQ_W   = 11;
   localparam int MODE_W   = 2;
   localparam int OP_W     = 2;
   localparam int TICKS_W  = 12;
   localparam int SAMPLE_W = 16;
   localparam int ADDR_W   = 2;
   localparam int TIMER_W  = 14;
   localparam int POS_W    = 3;
   localparam int ELAPSED_W = 16;
   localparam int SUM_W    = 17;

   // Longest run that one item may request.
   localparam logic [15:0] TICK_MAX = 16'd4095;

   // The timer period is (PERIOD_BASE - frequency) * 4 ticks.
   localparam logic [11:0] PERIOD_BASE = 12'd2048;

   // Q2.14 full-scale sample values.
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE       = 16'sd16384;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MINUS_ONE = -16'sd16384;

   // Shared divider: quotient bits produced, one per cycle.
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Item operation codes.
   localparam logic [OP_W-1:0] OP_RUN     = 2'd0;
   localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;

   // Configuration register indexes.
   localparam logic [ADDR_W-1:0] CSR_FREQUENCY    = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_DUTY_MODE    = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_BAND_LIMITED = 2'd2;

   // Duty patterns, bit n is the level at duty position n.
   localparam logic [7:0] DUTY_TABLE [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAND,
      ST_CHECK,
      ST_DIVIDE,
      ST_POST,
      ST_FINISH
   } state_type;

   // Level of the duty pattern selected by mode at the given position.
   function automatic logic duty_level(input logic [MODE_W-1:0] mode,
                                       input logic [POS_W-1:0] pos);
      return DUTY_TABLE[mode][pos];
   endfunction

endpackage

// ----- sv/square_duty_wave_generator.sv -----
// Square duty wave generator: timer, duty sequencer, accumulators and a shared divider.
// Depends on sdwg_pkg and assert_macros.svh.
//
// Usage: items enter on the req_ channel (req_operation, req_run_ticks) with valid and
// ready; each item yields exactly one result on the rsp_ channel (rsp_level, rsp_sample).
// Registers frequency, duty_mode and band_limited are written on the csr_ channel
// (index on csr_addr, data on csr_wdata); csr_ready is high. The user must write them
// only while no item is in flight; the block itself does not enforce this.
// Path through the sequencer: trigger, plain sample, runs that do not wrap the timer,
// band-limited runs while aliased and band-limited samples with nothing to average
// go from IDLE straight to FINISH, where the result is loaded. Other band-limited
// runs pass through BAND; a band-limited sample whose average is full scale passes
// CHECK; a plain run that wraps the timer passes DIVIDE and POST; and a band-limited
// sample that divides passes CHECK, DIVIDE and POST. DIVIDE runs the 16-step restoring
// divider, one quotient bit a cycle, which is shared by the wrap count and the sample
// average. The block takes one item at a time; req_ready rises at the edge that loads
// the result. A result sits in the output register until taken; a new item may be
// accepted meanwhile, and its result waits for the register to free.
// Synchronous reset clears the configuration registers, the sequencer state, the timer,
// duty position, flags, accumulators and rsp_valid; no item or result is pending after reset.
`include "assert_macros.svh"

module square_duty_wave_generator (
   input  logic                                clock,
   input  logic                                reset,
   // Item input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sdwg_pkg::OP_W-1:0]           req_operation,
   input  logic [sdwg_pkg::TICKS_W-1:0]        req_run_ticks,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_level,
   output logic signed [sdwg_pkg::SAMPLE_W-1:0] rsp_sample,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdwg_pkg::ADDR_W-1:0]         csr_addr,
   input  logic [sdwg_pkg::FREQ_W-1:0]         csr_wdata
);
   import sdwg_pkg::*;

   // Saturating add of +amount or -amount to the level sum.
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] acc,
                                                       input logic lvl,
                                                       input logic [TIMER_W-1:0] amt);
      logic signed [SUM_W:0] amt_s;
      logic signed [SUM_W:0] s;
      amt_s = $signed({4'b0, amt});
      s = $signed({acc[SUM_W-1], acc}) + (lvl ? amt_s : -amt_s);
      if (s > 18'sd65535) begin
         return 17'sh0FFFF;
      end
      if (s < -18'sd65536) begin
         return 17'sh10000;
      end
      return s[SUM_W-1:0];
   endfunction

   // Configuration registers.
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              band_ff, band_in;

   // Generator state.
   logic [TIMER_W-1:0]          timer_ff, timer_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic                        trans_ff, trans_in;
   logic                        alias_ff, alias_in;
   logic [ELAPSED_W-1:0]        elapsed_ff, elapsed_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;

   // Sequencer and working registers.
   state_type                   state_ff, state_in;
   logic [TICKS_W-1:0]          ticks_ff, ticks_in;
   logic [1:0]                  pass_ff, pass_in;
   logic                        div_band_ff, div_band_in;
   logic                        neg_ff, neg_in;
   logic [SUM_W-1:0]            rem_ff, rem_in;
   logic [DIV_STEPS-1:0]        num_ff, num_in;
   logic [SUM_W-1:0]            den_ff, den_in;
   logic [DIV_CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0]  result_ff, result_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_level_ff, rsp_level_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;

   // Shared combinational terms.
   logic                 req_fire;
   logic                 out_free;
   logic [TICKS_W-1:0]   ticks_c;
   logic [TIMER_W-1:0]   period;
   logic                 cur_lvl;
   logic                 plain_fits;
   logic                 band_fits;
   logic                 sample_divides;
   logic                 div_last;
   logic [ELAPSED_W:0]   elapsed_sum;
   logic signed [SUM_W:0] sum_wide;
   logic [SUM_W:0]       sum_abs;
   logic [32:0]          numer;
   logic [SUM_W:0]       trial;
   logic [SUM_W:0]       trial_diff;
   logic                 trial_ge;
   logic [DIV_STEPS-1:0] q_clamped;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_sample = rsp_sample_ff;

   // Requested tick count, limited to the longest allowed run.
   assign ticks_c = ({4'b0, req_run_ticks} > TICK_MAX) ? TICK_MAX[TICKS_W-1:0]
                                                       : req_run_ticks;
   assign period  = {PERIOD_BASE - {1'b0, freq_ff}, 2'b00};
   assign cur_lvl = duty_level(mode_ff, pos_ff);

   // Timer compares for the plain run at acceptance and for each band-limited pass.
   assign plain_fits = timer_ff > {2'b0, ticks_c};
   assign band_fits  = timer_ff > {2'b0, ticks_ff};
   assign sample_divides = band_ff && (elapsed_ff != '0) && !alias_ff;
   assign div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Accumulator helpers and the sample dividend: |sum| * 32768 + elapsed.
   assign elapsed_sum = {1'b0, elapsed_ff} + {5'b0, ticks_c};
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff};
   assign sum_abs  = sum_ff[SUM_W-1] ? 18'(-sum_wide) : 18'(sum_wide);
   assign numer    = {1'b0, sum_abs[SUM_W-1:0], 15'b0} + {17'b0, elapsed_ff};

   // One restoring division step.
   assign trial      = {rem_ff, num_ff[DIV_STEPS-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};
   assign q_clamped  = (num_ff > 16'd16384) ? 16'd16384 : num_ff;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_operation)
                  OP_RUN: begin
                     if (band_ff) begin
                        state_in = alias_ff ? ST_FINISH : ST_BAND;
                     end else begin
                        state_in = plain_fits ? ST_FINISH : ST_DIVIDE;
                     end
                  end
                  OP_SAMPLE: state_in = sample_divides ? ST_CHECK : ST_FINISH;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_BAND: begin
            if (band_fits || trans_ff || (pass_ff == 2'd2)) begin
               state_in = ST_FINISH;
            end
         end
         ST_CHECK:  state_in = (rem_ff >= den_ff) ? ST_FINISH : ST_DIVIDE;
         ST_DIVIDE: state_in = div_last ? ST_POST : ST_DIVIDE;
         ST_POST:   state_in = ST_FINISH;
         ST_FINISH: state_in = out_free ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates driven by the sequencer state.
   always_comb begin
      timer_in    = timer_ff;
      pos_in      = pos_ff;
      trans_in    = trans_ff;
      alias_in    = alias_ff;
      elapsed_in  = elapsed_ff;
      sum_in      = sum_ff;
      ticks_in    = ticks_ff;
      pass_in     = pass_ff;
      div_band_in = div_band_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      cnt_in      = cnt_ff;
      result_in   = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               result_in = '0;
               cnt_in    = '0;
               case (req_operation)
                  OP_RUN: begin
                     if (band_ff) begin
                        // Band-limited run: count the ticks once, then walk the timer.
                        if (!alias_ff) begin
                           elapsed_in = elapsed_sum[ELAPSED_W] ? '1
                                                               : elapsed_sum[ELAPSED_W-1:0];
                           ticks_in = ticks_c;
                           pass_in  = '0;
                        end
                     end else if (plain_fits) begin
                        timer_in = timer_ff - {2'b0, ticks_c};
                     end else begin
                        // Timer wraps: divide the deficit by the period.
                        div_band_in = 1'b0;
                        rem_in = '0;
                        num_in = {4'b0, ticks_c - timer_ff[TICKS_W-1:0]};
                        den_in = {3'b0, period};
                     end
                  end
                  OP_TRIGGER: begin
                     pos_in   = '0;
                     timer_in = period;
                  end
                  OP_SAMPLE: begin
                     if (!band_ff) begin
                        result_in = cur_lvl ? SAMPLE_ONE : SAMPLE_MINUS_ONE;
                     end else begin
                        // Latch the dividend and divisor, then clear the accumulators.
                        div_band_in = 1'b1;
                        neg_in = sum_ff[SUM_W-1];
                        rem_in = numer[32:16];
                        num_in = numer[15:0];
                        den_in = {elapsed_ff, 1'b0};
                        trans_in   = 1'b0;
                        alias_in   = 1'b0;
                        elapsed_in = '0;
                        sum_in     = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_BAND: begin
            // One pass of the band-limited run per cycle.
            if (band_fits) begin
               timer_in = timer_ff - {2'b0, ticks_ff};
               sum_in   = sat_sum(sum_ff, cur_lvl, {2'b0, ticks_ff});
            end else if (trans_ff) begin
               alias_in = 1'b1;
            end else begin
               trans_in = 1'b1;
               sum_in   = sat_sum(sum_ff, cur_lvl, timer_ff);
               pos_in   = pos_ff + 3'd1;
               ticks_in = ticks_ff - timer_ff[TICKS_W-1:0];
               timer_in = period;
               pass_in  = pass_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            // Quotient would not fit the divider: the average is full scale.
            if (rem_ff >= den_ff) begin
               result_in = neg_ff ? SAMPLE_MINUS_ONE : SAMPLE_ONE;
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_in = {num_ff[DIV_STEPS-2:0], trial_ge};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_POST: begin
            if (div_band_ff) begin
               result_in = neg_ff ? -$signed(q_clamped) : $signed(q_clamped);
            end else begin
               timer_in = period - rem_ff[TIMER_W-1:0];
               pos_in   = pos_ff + num_ff[POS_W-1:0] + 3'd1;
            end
         end
         default: ;
      endcase
   end

   // Output register: load a finished item, drop it once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_sample_in = rsp_sample_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = cur_lvl;
         rsp_sample_in = result_ff;
      end
   end

   // Configuration writes.
   always_comb begin
      freq_in = freq_ff;
      mode_in = mode_ff;
      band_in = band_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_FREQUENCY:    freq_in = csr_wdata;
            CSR_DUTY_MODE:    mode_in = csr_wdata[MODE_W-1:0];
            CSR_BAND_LIMITED: band_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Control and architectural state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= '0;
         mode_ff      <= '0;
         band_ff      <= 1'b0;
         timer_ff     <= '0;
         pos_ff       <= '0;
         trans_ff     <= 1'b0;
         alias_ff     <= 1'b0;
         elapsed_ff   <= '0;
         sum_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         mode_ff      <= mode_in;
         band_ff      <= band_in;
         timer_ff     <= timer_in;
         pos_ff       <= pos_in;
         trans_ff     <= trans_in;
         alias_ff     <= alias_in;
         elapsed_ff   <= elapsed_in;
         sum_ff       <= sum_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      ticks_ff      <= ticks_in;
      pass_ff       <= pass_in;
      div_band_ff   <= div_band_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      cnt_ff        <= cnt_in;
      result_ff     <= result_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // A second transition within one sample can only follow a first one.
   `ASSERT_IMPLY(a_alias_needs_trans, clock, reset, alias_ff, trans_ff, "aliased without transition")
   // The partial remainder stays below the divisor while dividing.
   `ASSERT_IMPLY(a_div_rem_bound, clock, reset, state_ff == ST_DIVIDE, rem_ff < den_ff, "remainder out of range")
   // A band-limited sample item leaves the accumulators and flags cleared.
   `ASSERT_NEXT(a_sample_clears, clock, reset, req_fire && (req_operation == OP_SAMPLE) && band_ff, (elapsed_ff == '0) && (sum_ff == '0) && !alias_ff && !trans_ff, "sample did not clear accumulators")
   // Samples never leave the Q2.14 range of -1 to +1.
   `ASSERT_IMPLY(a_sample_range, clock, reset, rsp_valid_ff, (rsp_sample_ff <= SAMPLE_ONE) && (rsp_sample_ff >= SAMPLE_MINUS_ONE), "sample out of range")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for square_duty_wave_generator: directed rows, then random phases.
// Depends on sdwg_pkg and the generator RTL; keeps its own duty, timer and averaging predictor.
module testbench;
   import sdwg_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
   localparam logic [ADDR_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                IDLE_LIMIT  = 3000;
   localparam int                RANDOM_ITEMS = 1900;

   // Duty patterns, bit n is the level at duty position n.
   localparam logic [7:0] DUTY_PATTERNS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

   typedef struct packed {
      logic                       level;
      logic signed [SAMPLE_W-1:0] sample;
   } wave_out_type;

   // One directed row: a register write or an item, with an optional typed expectation.
   typedef struct packed {
      logic                is_csr;
      logic [1:0]          code;
      logic [TICKS_W-1:0]  value;
      logic                typed;
      logic                lvl;
      logic [SAMPLE_W-1:0] smp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_operation = OP_RUN;
   logic [TICKS_W-1:0] req_run_ticks = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_level;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ADDR_W-1:0] csr_addr = CSR_FREQUENCY;
   logic [FREQ_W-1:0] csr_wdata = '0;

   square_duty_wave_generator DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_run_ticks(req_run_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_level(rsp_level),
      .rsp_sample(rsp_sample),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state: registers, timer, duty position, flags and accumulators.
   logic [FREQ_W-1:0] freq_reg = '0;
   logic [MODE_W-1:0] mode_reg = '0;
   logic              band_reg = 1'b0;
   int                timer_left = 0;
   logic [POS_W-1:0]  duty_pos = '0;
   logic              stepped = 1'b0;
   logic              aliased = 1'b0;
   int                elapsed = 0;
   int                level_sum = 0;

   wave_out_type waves_due [$];
   int        failures = 0;
   int        items_sent = 0;
   bit        steady = 1'b0;
   int        stall_left = 0;
   int        idle_cycles = 0;

   function automatic int wave_period();
      return (2048 - int'(freq_reg)) * 4;
   endfunction

   function automatic logic wave_level();
      return DUTY_PATTERNS[mode_reg][duty_pos];
   endfunction

   // Adds level times ticks to the running sum, saturating at the 17-bit limits.
   function automatic void add_level_time(int amount);
      int s;
      s = level_sum + (wave_level() ? amount : -amount);
      if (s > 65535) s = 65535;
      if (s < -65536) s = -65536;
      level_sum = s;
   endfunction

   // Plain run: count down, then step once per period that the run crossed.
   function automatic void run_plain(int ticks);
      int per;
      int deficit;
      per = wave_period();
      if (timer_left > ticks) begin
         timer_left = timer_left - ticks;
      end else begin
         deficit = ticks - timer_left;
         duty_pos = duty_pos + 3'(deficit / per + 1);
         timer_left = per - deficit % per;
      end
   endfunction

   // Band-limited run: integrate the level; a second step inside one sample marks it aliased.
   function automatic void run_band(int ticks);
      if (aliased) return;
      elapsed = elapsed + ticks;
      if (elapsed > 65535) elapsed = 65535;
      for (int pass = 0; pass < 3; pass++) begin
         if (timer_left > ticks) begin
            timer_left = timer_left - ticks;
            add_level_time(ticks);
            return;
         end
         if (stepped) begin
            aliased = 1'b1;
            return;
         end
         stepped = 1'b1;
         add_level_time(timer_left);
         duty_pos = duty_pos + 3'd1;
         ticks = ticks - timer_left;
         timer_left = wave_period();
      end
   endfunction

   // Sample: the level in plain mode, else the rounded Q2.14 average, after which the accumulators and flags clear.
   function automatic logic signed [SAMPLE_W-1:0] take_sample();
      longint mag;
      longint den;
      longint q;
      bit neg;
      logic signed [SAMPLE_W-1:0] result;
      if (!band_reg) return wave_level() ? SAMPLE_ONE : SAMPLE_MINUS_ONE;
      result = '0;
      if (elapsed > 0 && !aliased) begin
         neg = level_sum < 0;
         mag = neg ? -longint'(level_sum) : longint'(level_sum);
         den = elapsed;
         q = (mag * 32768 + den) / (2 * den);
         if (q > 16384) q = 16384;
         result = 16'(neg ? -q : q);
      end
      stepped = 1'b0;
      aliased = 1'b0;
      elapsed = 0;
      level_sum = 0;
      return result;
   endfunction

   function automatic wave_out_type wave_step(logic [OP_W-1:0] op, logic [TICKS_W-1:0] ticks);
      wave_out_type r;
      r.sample = '0;
      case (op)
         OP_RUN: begin
            if (band_reg) run_band(int'(ticks));
            else run_plain(int'(ticks));
         end
         OP_TRIGGER: begin
            duty_pos = '0;
            timer_left = wave_period();
         end
         OP_SAMPLE: r.sample = take_sample();
         default: ;
      endcase
      r.level = wave_level();
      return r;
   endfunction

   function automatic void apply_register(logic [ADDR_W-1:0] addr, logic [FREQ_W-1:0] data);
      case (addr)
         CSR_FREQUENCY:    freq_reg = data;
         CSR_DUTY_MODE:    mode_reg = data[MODE_W-1:0];
         CSR_BAND_LIMITED: band_reg = data[0];
         default: ;
      endcase
   endfunction

   // Sender gap: mostly none or short, a few long, none at all in steady phases.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Tick counts spread around the current period, with the field extremes.
   function automatic logic [TICKS_W-1:0] pick_ticks();
      int cap;
      int r;
      cap = wave_period();
      if (cap > 4095) cap = 4095;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return 12'd4095;
      if (r < 8) return 12'($urandom_range(0, cap / 4));
      if (r < 15) return 12'($urandom_range(0, cap));
      return 12'($urandom_range(0, 4095));
   endfunction

   // Sends one item; called and left at a falling edge with valid still high.
   task automatic push_item(input logic [OP_W-1:0] op, input logic [TICKS_W-1:0] ticks,
                            input logic typed, input logic lvl,
                            input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      wave_out_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_run_ticks <= ticks;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = wave_step(op, ticks);
      if (typed) begin
         predicted.level = lvl;
         predicted.sample = smp;
      end
      waves_due.push_back(predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Holds the sender until every expected result has been taken.
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (waves_due.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [FREQ_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(addr, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Directed rows: reset state, field extremes, every operation, aliasing and empty samples.
   row_type directed_rows [31] = '{
      '{1'b0, OP_SAMPLE,       12'd0,    1'b1, 1'b0, SAMPLE_MINUS_ONE},
      '{1'b0, OP_RUN,          12'd0,    1'b1, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd4095, 1'b1, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd4095, 1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_FREQUENCY,   12'd2047, 1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_DUTY_MODE,   12'd3,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_TRIGGER,      12'd0,    1'b1, 1'b0, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b1, 1'b0, SAMPLE_MINUS_ONE},
      '{1'b0, OP_RUN,          12'd4095, 1'b0, 1'b0, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_UNUSED,       12'd4095, 1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_BAND_LIMITED, 12'd1,   1'b0, 1'b0, 16'd0},
      '{1'b0, OP_TRIGGER,      12'd0,    1'b1, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd3,    1'b1, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd4095, 1'b1, 1'b1, 16'd0},
      '{1'b0, OP_RUN,          12'd10,   1'b1, 1'b1, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b1, 1'b1, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b1, 1'b1, 16'd0},
      '{1'b1, CSR_FREQUENCY,   12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_DUTY_MODE,   12'd2,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_TRIGGER,      12'd0,    1'b1, 1'b1, 16'd0},
      '{1'b0, OP_RUN,          12'd4095, 1'b0, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd4095, 1'b0, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd100,  1'b0, 1'b0, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_RUN,          12'd1,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_DUTY_MODE,   12'd1,    1'b0, 1'b0, 16'd0},
      '{1'b0, OP_SAMPLE,       12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_DUTY_MODE,   12'd0,    1'b0, 1'b0, 16'd0},
      '{1'b1, CSR_BAND_LIMITED, 12'd0,   1'b0, 1'b0, 16'd0}
   };

   // Receiver: random stalls, short mostly, some long, none in steady phases.
   always @(negedge clock) begin
      int r;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady) begin
            r = $urandom_range(0, 99);
            if (r < 20) stall_left = $urandom_range(1, 3);
            else if (r < 23) stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Result checker: each result against the oldest expectation.
   always @(posedge clock) begin
      wave_out_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (waves_due.size() == 0) begin
            $error("unexpected result: level %0d sample %0d", rsp_level, rsp_sample);
            failures++;
         end else begin
            due = waves_due.pop_front();
            if (rsp_level !== due.level) begin
               $error("level: expected %0d, actual %0d", due.level, rsp_level);
               failures++;
            end
            if (rsp_sample !== due.sample) begin
               $error("sample: expected %0d, actual %0d", due.sample, rsp_sample);
               failures++;
            end
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase_end;
      int r;
      int runs;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: register rows wait for the block to go idle first.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain_results();
            write_register(directed_rows[i].code, directed_rows[i].value[FREQ_W-1:0]);
         end else begin
            push_item(directed_rows[i].code, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].lvl, directed_rows[i].smp);
         end
      end

      // Random phases: new settings at each boundary, then mostly run/sample sequences.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         drain_results();
         steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 9);
         if (r == 0) write_register(CSR_FREQUENCY, 11'd0);
         else if (r == 1) write_register(CSR_FREQUENCY, 11'd2047);
         else if (r < 6) write_register(CSR_FREQUENCY, 11'($urandom_range(1900, 2047)));
         else write_register(CSR_FREQUENCY, 11'($urandom_range(0, 2047)));
         if ($urandom_range(0, 1) == 0)
            write_register(CSR_DUTY_MODE, 11'($urandom_range(0, 2047)));
         if ($urandom_range(0, 1) == 0)
            write_register(CSR_BAND_LIMITED, 11'($urandom_range(0, 2047)));
         if ($urandom_range(0, 7) == 0)
            write_register(CSR_UNUSED, 11'($urandom_range(0, 2047)));
         phase_end = items_sent + $urandom_range(40, 160);
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 9) < 7) begin
               if ($urandom_range(0, 3) == 0) push_item(OP_TRIGGER, pick_ticks(), 1'b0, 1'b0, 0);
               runs = $urandom_range(1, 5);
               repeat (runs) push_item(OP_RUN, pick_ticks(), 1'b0, 1'b0, 0);
               push_item(OP_SAMPLE, pick_ticks(), 1'b0, 1'b0, 0);
            end else begin
               push_item(OP_W'($urandom_range(0, 3)), pick_ticks(), 1'b0, 1'b0, 0);
            end
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end

      // Wind down: let every result arrive, then give the block a few more cycles.
      req_valid <= 1'b0;
      while (waves_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
